// ----- rtl/tpc_pkg.sv -----
`default_nettype none

package tpc_pkg;

    localparam int NODE_POOL   = 4096;
    localparam int ALPHABET    = 26;
    localparam int COUNT_BITS  = 16;

    localparam int NODE_BITS   = $clog2(NODE_POOL);
    localparam int FREE_BITS   = $clog2(NODE_POOL + 1);
    localparam int LETTER_BITS = 5;
    localparam int SLOT_COUNT  = NODE_POOL * ALPHABET;
    localparam int SLOT_BITS   = $clog2(SLOT_COUNT);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // per-node record: the slot that owns the node, plus its prefix count
    typedef struct packed {
        logic [NODE_BITS-1:0]   parent;
        logic [LETTER_BITS-1:0] letter;
        logic [COUNT_BITS-1:0]  count;
    } node_t;

    typedef struct packed {
        logic load;
        logic fetch;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_blocked;
    } status_t;

endpackage

`default_nettype wire

// ----- rtl/tpc_ctrl.sv -----
`default_nettype none

module tpc_ctrl (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    input  tpc_pkg::status_t status,
    output tpc_pkg::cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LINK = 2'd1;
    localparam logic [1:0] ST_NODE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LINK;
                end
            end
            ST_LINK:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_NODE;
            end
            ST_NODE:
            begin
                // on a last letter, hold the decision until the result register can take it
                if (!(status.last && status.out_blocked))
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.fetch, cmd.commit}))
        else $error("more than one datapath command at once");

    a_load_then_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.fetch)
        else $error("link read not followed by node read");

    a_fetch_then_node: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |=> (state_reg == ST_NODE))
        else $error("node stage skipped");

endmodule

`default_nettype wire

// ----- rtl/tpc_datapath.sv -----
`default_nettype none

module tpc_datapath (
    input  wire                               clk,
    input  wire                               rst_n,
    input  tpc_pkg::cmd_t                     cmd,
    output tpc_pkg::status_t                  status,
    input  wire                               kind,
    input  wire  [tpc_pkg::LETTER_BITS-1:0]   letter,
    input  wire                               first,
    input  wire                               last,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [tpc_pkg::COUNT_BITS-1:0]    prefix_count,
    output logic                              pool_full
);

    // child table and node records; neither is cleared. A link is trusted only
    // if it points below next_free and that node's record names this very slot
    bit   [tpc_pkg::NODE_BITS-1:0] child_mem [0:tpc_pkg::SLOT_COUNT-1];
    tpc_pkg::node_t                node_mem  [0:tpc_pkg::NODE_POOL-1];

    logic [tpc_pkg::NODE_BITS-1:0]   cursor_reg,    cursor_next;
    logic [tpc_pkg::FREE_BITS-1:0]   next_free_reg, next_free_next;
    logic                            missed_reg,    missed_next;
    logic                            overflowed_reg, overflowed_next;
    logic                            kind_reg;
    logic [tpc_pkg::LETTER_BITS-1:0] letter_reg;
    logic                            last_reg;
    logic [tpc_pkg::SLOT_BITS-1:0]   slot_reg;
    logic [tpc_pkg::NODE_BITS-1:0]   link_rd_reg;
    tpc_pkg::node_t                  node_rd_reg;

    logic                            out_valid_reg, out_valid_next;
    logic [tpc_pkg::COUNT_BITS-1:0]  prefix_count_reg;
    logic                            pool_full_reg;

    // load-time values
    logic [tpc_pkg::NODE_BITS-1:0]   start_cursor;
    logic                            letter_ok;
    logic [tpc_pkg::LETTER_BITS-1:0] letter_sel;
    logic [tpc_pkg::SLOT_BITS-1:0]   slot_addr;

    // commit-time values
    logic                            walk_ok;
    logic                            link_ok;
    logic                            pool_left;
    logic                            alloc;
    logic                            child_we;
    logic                            node_we;
    logic [tpc_pkg::NODE_BITS-1:0]   node_wa;
    tpc_pkg::node_t                  node_wd;
    logic [tpc_pkg::COUNT_BITS-1:0]  count_inc;
    logic                            ovf_final;

    assign start_cursor = first ? '0 : cursor_reg;
    assign letter_ok    = (letter < tpc_pkg::LETTER_BITS'(tpc_pkg::ALPHABET));
    assign letter_sel   = letter_ok ? letter : '0;
    assign slot_addr    = tpc_pkg::SLOT_BITS'(start_cursor)
                        * tpc_pkg::SLOT_BITS'(tpc_pkg::ALPHABET)
                        + tpc_pkg::SLOT_BITS'(letter_sel);

    assign walk_ok   = !missed_reg && !overflowed_reg;
    assign link_ok   = (link_rd_reg != '0)
                    && ({1'b0, link_rd_reg} < next_free_reg)
                    && (node_rd_reg.parent == cursor_reg)
                    && (node_rd_reg.letter == letter_reg);
    assign pool_left = (next_free_reg < tpc_pkg::FREE_BITS'(tpc_pkg::NODE_POOL));
    assign alloc     = cmd.commit && walk_ok && (kind_reg == tpc_pkg::KIND_INSERT)
                    && !link_ok && pool_left;
    assign count_inc = (node_rd_reg.count == tpc_pkg::COUNT_MAX)
                     ? node_rd_reg.count : node_rd_reg.count + 1'b1;
    assign ovf_final = overflowed_reg
                    || (walk_ok && (kind_reg == tpc_pkg::KIND_INSERT)
                        && !link_ok && !pool_left);

    assign child_we = alloc;

    always_comb
    begin
        node_we = 1'b0;
        node_wa = link_rd_reg;
        node_wd = node_rd_reg;
        if (alloc)
        begin
            node_we        = 1'b1;
            node_wa        = next_free_reg[tpc_pkg::NODE_BITS-1:0];
            node_wd.parent = cursor_reg;
            node_wd.letter = letter_reg;
            node_wd.count  = tpc_pkg::COUNT_BITS'(1);
        end
        else if (cmd.commit && walk_ok && (kind_reg == tpc_pkg::KIND_INSERT) && link_ok)
        begin
            node_we       = 1'b1;
            node_wd.count = count_inc;
        end
    end

    always_comb
    begin
        cursor_next     = cursor_reg;
        next_free_next  = next_free_reg;
        missed_next     = missed_reg;
        overflowed_next = overflowed_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            cursor_next     = start_cursor;
            missed_next     = (first ? 1'b0 : missed_reg) | !letter_ok;
            overflowed_next = first ? 1'b0 : overflowed_reg;
        end
        else if (cmd.commit)
        begin
            if (walk_ok)
            begin
                if (link_ok)
                    cursor_next = link_rd_reg;
                else if (kind_reg == tpc_pkg::KIND_QUERY)
                    missed_next = 1'b1;
                else if (pool_left)
                begin
                    cursor_next    = next_free_reg[tpc_pkg::NODE_BITS-1:0];
                    next_free_next = next_free_reg + 1'b1;
                end
                else
                    overflowed_next = 1'b1;
            end
            if (last_reg)
            begin
                out_valid_next  = 1'b1;
                cursor_next     = '0;
                missed_next     = 1'b0;
                overflowed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg     <= '0;
            next_free_reg  <= tpc_pkg::FREE_BITS'(1);
            missed_reg     <= 1'b0;
            overflowed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cursor_reg     <= cursor_next;
            next_free_reg  <= next_free_next;
            missed_reg     <= missed_next;
            overflowed_reg <= overflowed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= kind;
            letter_reg <= letter_sel;
            last_reg   <= last;
            slot_reg   <= slot_addr;
        end
        if (cmd.commit && last_reg)
        begin
            if (kind_reg == tpc_pkg::KIND_QUERY)
            begin
                prefix_count_reg <= (walk_ok && link_ok) ? node_rd_reg.count : '0;
                pool_full_reg    <= 1'b0;
            end
            else
            begin
                prefix_count_reg <= '0;
                pool_full_reg    <= ovf_final;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (child_we)
            child_mem[slot_reg] <= next_free_reg[tpc_pkg::NODE_BITS-1:0];
        if (cmd.load)
            link_rd_reg <= child_mem[slot_addr];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_wa] <= node_wd;
        if (cmd.fetch)
            node_rd_reg <= node_mem[link_rd_reg];
    end

    assign status.last        = last_reg;
    assign status.out_blocked = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign prefix_count = prefix_count_reg;
    assign pool_full    = pool_full_reg;

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != '0) && (next_free_reg <= tpc_pkg::FREE_BITS'(tpc_pkg::NODE_POOL)))
        else $error("free pointer out of range");

    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |=> (next_free_reg == tpc_pkg::FREE_BITS'($past(next_free_reg) + 1'b1)))
        else $error("allocation did not advance free pointer");

    a_walk_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && last_reg) |=> (cursor_reg == '0) && !missed_reg && !overflowed_reg)
        else $error("walk state not cleared at string end");

    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(pool_full_reg && (prefix_count_reg != '0)))
        else $error("result carries both a count and a pool-full flag");

endmodule

`default_nettype wire

// ----- rtl/trie_prefix_counter.sv -----
// trie_prefix_counter: prefix-count trie over a pool of 4096 nodes, 26 links each.
//
// Input channel (in_valid/in_ready): one letter per transaction with kind
// (insert or query), letter index, first and last marks. Output channel
// (out_valid/out_ready): one transaction per string, at its last letter:
// prefix_count for a query, pool_full for an insert.
//
// Each letter goes through a child-table read, a node-record read, then the
// update (allocation or count bump). in_ready is high only between letters,
// so a letter is not accepted until the previous one's update is done. A
// last letter's result appears on out_valid the cycle after its update.
//
// The result sits in an output register; the next string's letters are still
// accepted while it waits. Only a following last letter stalls at its update
// step until the held result is taken.
//
// Reset clears the walk state and the free pointer. The tables are not swept:
// a stored link counts only if it points at an allocated node whose record
// names the same parent and letter, so there is no clearing pass after reset.
`default_nettype none

module trie_prefix_counter (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire                               kind,
    input  wire  [tpc_pkg::LETTER_BITS-1:0]   letter,
    input  wire                               first,
    input  wire                               last,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [tpc_pkg::COUNT_BITS-1:0]    prefix_count,
    output logic                              pool_full
);

    tpc_pkg::cmd_t    cmd;
    tpc_pkg::status_t status;

    tpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tpc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .letter       (letter),
        .first        (first),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .prefix_count (prefix_count),
        .pool_full    (pool_full)
    );

endmodule

`default_nettype wire
